[rtl/core/scfar_pkg.sv]
package scfar_pkg;

    localparam int FRAME_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    localparam logic [7:0] HDR_RX    = 8'hEA;
    localparam logic [7:0] HDR_TX    = 8'hEB;
    localparam logic [7:0] ACK_LEN   = 8'h08;
    localparam logic [7:0] CMD_MONEY = 8'hA1;
    localparam logic [7:0] CMD_COIN  = 8'hA4;
    localparam logic [7:0] SUB_STATE = 8'hC2;

    localparam logic [1:0] KIND_RX   = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    localparam logic [1:0] RK_CMD  = 2'd0;
    localparam logic [1:0] RK_TX   = 2'd1;
    localparam logic [1:0] RK_DROP = 2'd2;

    localparam logic [1:0] SLOT_MONEY = 2'd0;
    localparam logic [1:0] SLOT_STATE = 2'd1;
    localparam logic [1:0] SLOT_COIN  = 2'd2;
    localparam int         NUM_SLOTS  = 3;

    localparam logic [2:0] LAST_BYTE = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [7:0] ack_cmd;
        logic [7:0] ack_data_a;
        logic [7:0] ack_data_b;
        logic [7:0] ack_data_c;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] frame_seq;
        logic [7:0] command_type;
        logic [7:0] sub_cmd_a;
        logic [7:0] sub_cmd_b;
        logic [7:0] sub_cmd_c;
        logic [7:0] tx_byte;
        logic       last;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_DROP,
        JOB_PKT
    } job_kind_t;

    // for JOB_CMD: byte 0 seq, 1 cmd, 2..4 sub bytes; for JOB_PKT: reply bytes 0..7
    typedef struct packed {
        job_kind_t   jkind;
        logic [63:0] data;
    } job_t;

endpackage

[rtl/core/serial_command_frame_with_ack_replay.sv]
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data (in_item_t)
// out       output     out_valid / out_ready out_data (out_item_t)
// cfg       input      cfg_wr_en             cfg_wr_data (timeout ticks)
//
// the front takes one transaction per cycle while its two-entry job queue has room
// a byte or tick result leaves as one output transaction, an acknowledge reply as eight,
// one byte per cycle from the output stage while out_ready is high
// the front keeps accepting while the output stage works through a reply
// stalls on out_ready back up through the queue to in_ready
// rst_n clears frame state, sequence tracking and the three reply slots at once
module serial_command_frame_with_ack_replay #(
    parameter int FRAME_BYTES = scfar_pkg::FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  scfar_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scfar_pkg::out_item_t out_data,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data
);
    import scfar_pkg::*;

    logic take;
    logic push;
    job_t push_job;
    logic pop;
    logic q_valid;
    job_t q_job;
    logic full;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;

    scfar_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .item        (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .push_job    (push_job)
    );

    scfar_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .full     (full)
    );

    scfar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/core/scfar_front.sv]
module scfar_front #(
    parameter int FRAME_BYTES = scfar_pkg::FRAME_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  scfar_pkg::in_item_t item,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    output logic               push,
    output scfar_pkg::job_t    push_job
);
    import scfar_pkg::*;

    localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int IW = $clog2(FRAME_BYTES + 1);
    localparam logic [7:0] FB8 = 8'(FRAME_BYTES);

    logic [15:0]   timeout_reg;
    logic          in_frame_reg, in_frame_next;
    logic [IW-1:0] byte_index_reg, byte_index_next;
    logic [7:0]    running_xor_reg, running_xor_next;
    logic [15:0]   ticks_left_reg, ticks_left_next;
    logic [7:0]    received_seq_reg, received_seq_next;
    logic [7:0]    acked_seq_reg, acked_seq_next;
    logic [7:0]    last_sub_reg, last_sub_next;
    logic [63:0]   cache_reg [NUM_SLOTS];
    logic [63:0]   cache_wdata;
    logic          cache_we;
    logic [7:0]    store_reg [FRAME_BYTES];
    logic          store_we;
    logic [AW-1:0] store_idx;

    logic [7:0]    view [FRAME_BYTES];
    logic [7:0]    len;
    logic [7:0]    fld [3:6];
    logic [7:0]    b;
    logic [1:0]    slot;
    logic          slot_ok;
    logic [7:0]    ack_x;
    logic [63:0]   ack_pkt;
    logic [IW:0]   pos_inc;

    assign b = item.rx_byte;

    // current byte forwarded so fields of the closing byte read correctly
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            view[i] = (byte_index_reg == IW'(i)) ? b : store_reg[i];
        end
        len = view[2];
        for (int p = 3; p <= 6; p++)
        begin
            fld[p] = (8'(p) < len) ? view[p] : 8'h00;
        end
    end

    always_comb
    begin
        slot    = SLOT_MONEY;
        slot_ok = 1'b0;
        priority if (item.ack_cmd == CMD_MONEY)
        begin
            slot    = (last_sub_reg == SUB_STATE) ? SLOT_STATE : SLOT_MONEY;
            slot_ok = 1'b1;
        end
        else if (item.ack_cmd == CMD_COIN)
        begin
            slot    = SLOT_COIN;
            slot_ok = 1'b1;
        end
        ack_x   = HDR_TX ^ received_seq_reg ^ ACK_LEN ^ item.ack_cmd
                ^ item.ack_data_a ^ item.ack_data_b ^ item.ack_data_c;
        ack_pkt = {ack_x, item.ack_data_c, item.ack_data_b, item.ack_data_a,
                   item.ack_cmd, ACK_LEN, received_seq_reg, HDR_TX};
    end

    assign pos_inc = {1'b0, byte_index_reg} + (IW + 1)'(1);

    always_comb
    begin
        in_frame_next     = in_frame_reg;
        byte_index_next   = byte_index_reg;
        running_xor_next  = running_xor_reg;
        ticks_left_next   = ticks_left_reg;
        received_seq_next = received_seq_reg;
        acked_seq_next    = acked_seq_reg;
        last_sub_next     = last_sub_reg;
        cache_we          = 1'b0;
        cache_wdata       = ack_pkt;
        store_we          = 1'b0;
        store_idx         = byte_index_reg[AW-1:0];
        push              = 1'b0;
        push_job          = '{jkind: JOB_DROP, data: '0};

        if (take)
        begin
            unique case (item.kind)
                KIND_RX:
                begin
                    if (!in_frame_reg)
                    begin
                        if (b == HDR_RX)
                        begin
                            if (timeout_reg == 16'd0)
                            begin
                                push = 1'b1;
                            end
                            else
                            begin
                                store_we         = 1'b1;
                                store_idx        = '0;
                                byte_index_next  = IW'(1);
                                running_xor_next = b;
                                ticks_left_next  = timeout_reg;
                                in_frame_next    = 1'b1;
                            end
                        end
                    end
                    else if ({1'b0, byte_index_reg} >= (IW + 1)'(FRAME_BYTES))
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        store_we        = 1'b1;
                        byte_index_next = pos_inc[IW-1:0];
                        if (byte_index_reg < IW'(2))
                        begin
                            running_xor_next = running_xor_reg ^ b;
                        end
                        else if (len > FB8 || len < 8'd3)
                        begin
                            push = 1'b1;
                        end
                        else if (8'(pos_inc) == len)
                        begin
                            if (b != running_xor_reg)
                            begin
                                push = 1'b1;
                            end
                            else
                            begin
                                received_seq_next = view[1];
                                last_sub_next     = fld[5];
                                push              = 1'b1;
                                push_job.jkind    = JOB_CMD;
                                push_job.data     = {24'h0, fld[6], fld[5], fld[4],
                                                     fld[3], view[1]};
                                in_frame_next     = 1'b0;
                                byte_index_next   = '0;
                                running_xor_next  = 8'h00;
                                ticks_left_next   = 16'd0;
                            end
                        end
                        else
                        begin
                            running_xor_next = running_xor_reg ^ b;
                        end
                    end
                end
                KIND_TICK:
                begin
                    if (in_frame_reg)
                    begin
                        ticks_left_next = (ticks_left_reg != 16'd0) ?
                                          ticks_left_reg - 16'd1 : 16'd0;
                        if (ticks_left_next == 16'd0)
                        begin
                            push = 1'b1;
                        end
                    end
                end
                KIND_ACK:
                begin
                    if (received_seq_reg != acked_seq_reg)
                    begin
                        acked_seq_next = received_seq_reg;
                        cache_we       = slot_ok;
                        push           = 1'b1;
                        push_job.jkind = JOB_PKT;
                        push_job.data  = ack_pkt;
                    end
                    else if (slot_ok)
                    begin
                        push           = 1'b1;
                        push_job.jkind = JOB_PKT;
                        push_job.data  = cache_reg[slot];
                    end
                end
                default:
                begin
                end
            endcase

            // drop clears the frame
            if (push && push_job.jkind == JOB_DROP)
            begin
                in_frame_next    = 1'b0;
                byte_index_next  = '0;
                running_xor_next = 8'h00;
                ticks_left_next  = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg      <= TIMEOUT_RESET;
            in_frame_reg     <= 1'b0;
            byte_index_reg   <= '0;
            running_xor_reg  <= 8'h00;
            ticks_left_reg   <= 16'd0;
            received_seq_reg <= 8'h00;
            acked_seq_reg    <= 8'h00;
            last_sub_reg     <= 8'h00;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                cache_reg[s] <= 64'h0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            in_frame_reg     <= in_frame_next;
            byte_index_reg   <= byte_index_next;
            running_xor_reg  <= running_xor_next;
            ticks_left_reg   <= ticks_left_next;
            received_seq_reg <= received_seq_next;
            acked_seq_reg    <= acked_seq_next;
            last_sub_reg     <= last_sub_next;
            if (cache_we)
            begin
                cache_reg[slot] <= cache_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[store_idx] <= b;
        end
    end

endmodule

[rtl/core/scfar_queue.sv]
module scfar_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scfar_pkg::job_t push_job,
    input  logic            pop,
    output logic            q_valid,
    output scfar_pkg::job_t q_job,
    output logic            full
);
    import scfar_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign q_valid = (count_reg != '0);
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_job   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[rtl/core/scfar_back.sv]
module scfar_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  scfar_pkg::job_t      q_job,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scfar_pkg::out_item_t out_data
);
    import scfar_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    job_t       cur_reg, cur_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       done;
    logic       load;

    assign out_valid = cur_valid_reg;
    assign done = cur_valid_reg && out_ready
               && (cur_reg.jkind != JOB_PKT || cnt_reg == LAST_BYTE);
    assign load = !cur_valid_reg || done;
    assign pop  = load && q_valid;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        if (load)
        begin
            cur_valid_next = q_valid;
            cur_next       = q_job;
            cnt_next       = 3'd0;
        end
        else if (cur_valid_reg && out_ready)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_comb
    begin
        out_data = '0;
        unique case (cur_reg.jkind)
            JOB_CMD:
            begin
                out_data.result_kind  = RK_CMD;
                out_data.frame_seq    = cur_reg.data[7:0];
                out_data.command_type = cur_reg.data[15:8];
                out_data.sub_cmd_a    = cur_reg.data[23:16];
                out_data.sub_cmd_b    = cur_reg.data[31:24];
                out_data.sub_cmd_c    = cur_reg.data[39:32];
            end
            JOB_PKT:
            begin
                out_data.result_kind = RK_TX;
                out_data.tx_byte     = cur_reg.data[{cnt_reg, 3'b000} +: 8];
                out_data.last        = (cnt_reg == LAST_BYTE);
            end
            default:
            begin
                out_data.result_kind = RK_DROP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

[rtl/core/scfar_checker.sv]
module scfar_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input scfar_pkg::out_item_t out_data
);
    import scfar_pkg::*;

    // stalled transaction stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // reply bytes follow each other until the last one
    a_reply_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.result_kind == RK_TX && !out_data.last
        |=> out_valid && out_data.result_kind == RK_TX)
        else $error("reply frame broken before its last byte");

    // non-transmit results carry no reply byte
    a_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind != RK_TX
        |-> out_data.tx_byte == 8'h00 && !out_data.last)
        else $error("reply byte on a non-transmit result");

    // drop results are bare
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RK_DROP
        |-> out_data.frame_seq == 8'h00 && out_data.command_type == 8'h00
            && out_data.sub_cmd_a == 8'h00)
        else $error("drop result carries frame fields");

endmodule

bind serial_command_frame_with_ack_replay scfar_checker u_scfar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
    import scfar_pkg::*;

    localparam int FRAME_BYTES    = FRAME_BYTES_DEF;
    localparam int N_DIR          = 29;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ONE
    } chk_mode_t;

    typedef struct {
        in_item_t  stim;
        chk_mode_t mode;
        out_item_t want;
    } dir_row_t;

    localparam out_item_t DROPPED = {RK_DROP, 49'd0};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    serial_command_frame_with_ack_replay DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // frame receiver state as the block should hold it
    logic [15:0] p_timeout;
    logic [7:0]  p_store [FRAME_BYTES];
    int unsigned p_index;
    logic        p_open;
    logic [7:0]  p_xor;
    logic [15:0] p_ticks;
    logic [7:0]  p_rx_seq;
    logic [7:0]  p_ack_seq;
    logic [7:0]  p_sub;
    logic [63:0] p_slots [NUM_SLOTS];

    out_item_t   step_outputs [$];
    out_item_t   due_outputs [$];

    int unsigned mismatches = 0;
    int unsigned work_items = 0;
    int unsigned quiet_cycles = 0;
    int unsigned in_idle_pct;
    int unsigned out_idle_pct = 0;
    logic [7:0]  good_seq = 8'h00;

    dir_row_t directed [N_DIR] = '{
        '{{KIND_ACK, 8'h00, CMD_MONEY, 8'h11, 8'h22, 8'h33}, CHK_PREDICT, '0},
        '{{KIND_RX, 8'h00, 32'd0}, CHK_NONE, '0},
        '{{KIND_TICK, 8'h00, 32'd0}, CHK_NONE, '0},
        '{{KIND_UNUSED, 40'hFF_FFFF_FFFF}, CHK_NONE, '0},
        // full length frame, header value reused as data
        '{{KIND_RX, HDR_RX, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h01, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h08, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, HDR_RX, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h00, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, SUB_STATE, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'hFF, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h34, 32'd0}, CHK_ONE,
          {RK_CMD, 8'h01, HDR_RX, 8'h00, SUB_STATE, 8'hFF, 8'h00, 1'b0}},
        '{{KIND_ACK, 8'h00, CMD_MONEY, 8'hFF, 8'h00, 8'h80}, CHK_PREDICT, '0},
        '{{KIND_ACK, 8'h00, CMD_MONEY, 8'h00, 8'h00, 8'h00}, CHK_PREDICT, '0},
        '{{KIND_ACK, 8'h00, 8'h5A, 8'h01, 8'h02, 8'h03}, CHK_NONE, '0},
        // length out of range
        '{{KIND_RX, HDR_RX, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h02, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'hFF, 32'd0}, CHK_ONE, DROPPED},
        // short frame with an acknowledge in the middle
        '{{KIND_RX, HDR_RX, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h03, 32'd0}, CHK_NONE, '0},
        '{{KIND_ACK, 8'h00, CMD_COIN, 8'h01, 8'h02, 8'h03}, CHK_PREDICT, '0},
        '{{KIND_RX, 8'h05, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h7E, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h92, 32'd0}, CHK_ONE,
          {RK_CMD, 8'h03, 8'h7E, 8'h92, 8'h00, 8'h00, 8'h00, 1'b0}},
        // bad checksum
        '{{KIND_RX, HDR_RX, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h04, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h04, 32'd0}, CHK_NONE, '0},
        '{{KIND_RX, 8'h00, 32'd0}, CHK_ONE, DROPPED},
        '{{KIND_ACK, 8'h00, CMD_COIN, 8'hA5, 8'h5A, 8'hC3}, CHK_PREDICT, '0}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic [7:0] frame_field(input int unsigned pos, input int unsigned len);
        if (pos >= len || pos >= FRAME_BYTES)
            return 8'h00;
        return p_store[pos];
    endfunction

    task automatic frame_dropped();
        out_item_t r;
        r = '0;
        r.result_kind = RK_DROP;
        p_open = 1'b0;
        p_index = 0;
        p_xor = 8'h00;
        p_ticks = 16'd0;
        step_outputs.push_back(r);
    endtask

    task automatic reply_bytes(input logic [63:0] pkt);
        out_item_t r;
        for (int k = 0; k < 8; k++)
        begin
            r = '0;
            r.result_kind = RK_TX;
            r.tx_byte = pkt[8*k +: 8];
            r.last = (k == int'(LAST_BYTE));
            step_outputs.push_back(r);
        end
    endtask

    // fills step_outputs with what one transaction should produce
    task automatic frame_rx_step(input in_item_t it);
        out_item_t   r;
        int unsigned pos;
        int unsigned len;
        int          slot;
        logic [7:0]  x;
        logic [63:0] pkt;
        step_outputs.delete();
        case (it.kind)
            KIND_RX:
            begin
                if (!p_open)
                begin
                    if (it.rx_byte == HDR_RX)
                    begin
                        if (p_timeout == 16'd0)
                            frame_dropped();
                        else
                        begin
                            p_store[0] = it.rx_byte;
                            p_index = 1;
                            p_xor = it.rx_byte;
                            p_ticks = p_timeout;
                            p_open = 1'b1;
                        end
                    end
                end
                else if (p_index >= FRAME_BYTES)
                    frame_dropped();
                else
                begin
                    pos = p_index;
                    p_store[pos] = it.rx_byte;
                    p_index = pos + 1;
                    if (pos < 2)
                        p_xor ^= it.rx_byte;
                    else
                    begin
                        len = p_store[2];
                        if (len > FRAME_BYTES || len < 3)
                            frame_dropped();
                        else if (pos + 1 == len)
                        begin
                            if (it.rx_byte != p_xor)
                                frame_dropped();
                            else
                            begin
                                p_rx_seq = p_store[1];
                                p_sub = frame_field(5, len);
                                r = '0;
                                r.result_kind = RK_CMD;
                                r.frame_seq = p_store[1];
                                r.command_type = frame_field(3, len);
                                r.sub_cmd_a = frame_field(4, len);
                                r.sub_cmd_b = frame_field(5, len);
                                r.sub_cmd_c = frame_field(6, len);
                                step_outputs.push_back(r);
                                p_open = 1'b0;
                                p_index = 0;
                                p_xor = 8'h00;
                                p_ticks = 16'd0;
                            end
                        end
                        else
                            p_xor ^= it.rx_byte;
                    end
                end
            end
            KIND_TICK:
            begin
                if (p_open)
                begin
                    if (p_ticks > 0)
                        p_ticks--;
                    if (p_ticks == 0)
                        frame_dropped();
                end
            end
            KIND_ACK:
            begin
                if (it.ack_cmd == CMD_MONEY)
                    slot = (p_sub == SUB_STATE) ? int'(SLOT_STATE) : int'(SLOT_MONEY);
                else if (it.ack_cmd == CMD_COIN)
                    slot = int'(SLOT_COIN);
                else
                    slot = -1;
                if (p_rx_seq != p_ack_seq)
                begin
                    p_ack_seq = p_rx_seq;
                    x = HDR_TX ^ p_rx_seq ^ ACK_LEN ^ it.ack_cmd
                        ^ it.ack_data_a ^ it.ack_data_b ^ it.ack_data_c;
                    pkt = {x, it.ack_data_c, it.ack_data_b, it.ack_data_a,
                           it.ack_cmd, ACK_LEN, p_rx_seq, HDR_TX};
                    if (slot >= 0)
                        p_slots[slot] = pkt;
                    reply_bytes(pkt);
                end
                else if (slot >= 0)
                    reply_bytes(p_slots[slot]);
            end
            default: ;
        endcase
    endtask

    // entered and left at a falling edge; valid stays high for a following transaction
    task automatic send_item(input in_item_t it, input chk_mode_t mode = CHK_PREDICT,
                             input out_item_t want = '0);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        work_items++;
        frame_rx_step(it);
        if (mode == CHK_PREDICT)
            foreach (step_outputs[i])
                due_outputs.push_back(step_outputs[i]);
        else if (mode == CHK_ONE)
            due_outputs.push_back(want);
        @(negedge clk);
    endtask

    function automatic in_item_t rand_item(input logic [1:0] kind);
        in_item_t it;
        it.kind = kind;
        it.rx_byte = 8'($urandom);
        it.ack_cmd = 8'($urandom);
        it.ack_data_a = 8'($urandom);
        it.ack_data_b = 8'($urandom);
        it.ack_data_c = 8'($urandom);
        return it;
    endfunction

    task automatic send_ack();
        in_item_t    it;
        int unsigned pick;
        it = rand_item(KIND_ACK);
        pick = $urandom_range(9);
        if (pick < 4)
            it.ack_cmd = CMD_MONEY;
        else if (pick < 7)
            it.ack_cmd = CMD_COIN;
        send_item(it);
    endtask

    task automatic send_frame();
        logic [7:0]  fb [FRAME_BYTES];
        logic [7:0]  x;
        int unsigned len;
        int unsigned cut;
        int unsigned flaw;
        in_item_t    it;
        len = $urandom_range(4, FRAME_BYTES);
        fb[0] = HDR_RX;
        fb[1] = ($urandom_range(3) == 0) ? good_seq : 8'($urandom);
        fb[2] = 8'(len);
        for (int k = 3; k < FRAME_BYTES; k++)
            fb[k] = 8'($urandom);
        if (len >= 7 && $urandom_range(1) == 1)
            fb[5] = SUB_STATE;
        flaw = $urandom_range(9);
        // the length byte doubles as checksum when the length is three
        if (flaw == 3)
        begin
            len = 3;
            fb[1] = HDR_RX ^ 8'h03;
            fb[2] = 8'h03;
        end
        x = 8'h00;
        for (int k = 0; k < len - 1; k++)
            x ^= fb[k];
        fb[len - 1] = x;
        cut = len;
        case (flaw)
            0: fb[len - 1] = x ^ 8'($urandom_range(1, 255));
            1:
            begin
                fb[2] = ($urandom_range(1) == 1) ? 8'($urandom_range(0, 2))
                                                 : 8'($urandom_range(FRAME_BYTES + 1, 255));
                cut = 3;
            end
            2: cut = $urandom_range(1, len - 1);
            default: good_seq = fb[1];
        endcase
        for (int k = 0; k < cut; k++)
        begin
            it = rand_item(KIND_RX);
            it.rx_byte = fb[k];
            send_item(it);
            if (k + 1 < cut && $urandom_range(15) == 0)
                send_ack();
            else if (k + 1 < cut && $urandom_range(15) == 0)
                send_item(rand_item(KIND_TICK));
        end
        if (flaw == 2)
            repeat ($urandom_range(0, 24))
                send_item(rand_item(KIND_TICK));
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = work_items + n;
        while (work_items < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_frame();
            else if (pick < 80)
            begin
                send_ack();
                if ($urandom_range(2) == 0)
                    send_ack();
            end
            else if (pick < 90)
                send_item(rand_item(KIND_TICK));
            else if (pick < 96)
                send_item(rand_item(KIND_RX));
            else
                send_item(rand_item(KIND_UNUSED));
        end
    endtask

    task automatic set_timeout(input logic [15:0] ticks);
        in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        p_timeout = ticks;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_out
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_outputs.size() == 0)
                report_mismatch($sformatf("unexpected transaction %h", out_data));
            else
            begin
                want = due_outputs.pop_front();
                if (out_data.result_kind !== want.result_kind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              out_data.result_kind, want.result_kind));
                if (out_data.frame_seq !== want.frame_seq)
                    report_mismatch($sformatf("frame_seq %02h, expected %02h",
                                              out_data.frame_seq, want.frame_seq));
                if (out_data.command_type !== want.command_type)
                    report_mismatch($sformatf("command_type %02h, expected %02h",
                                              out_data.command_type, want.command_type));
                if (out_data.sub_cmd_a !== want.sub_cmd_a)
                    report_mismatch($sformatf("sub_cmd_a %02h, expected %02h",
                                              out_data.sub_cmd_a, want.sub_cmd_a));
                if (out_data.sub_cmd_b !== want.sub_cmd_b)
                    report_mismatch($sformatf("sub_cmd_b %02h, expected %02h",
                                              out_data.sub_cmd_b, want.sub_cmd_b));
                if (out_data.sub_cmd_c !== want.sub_cmd_c)
                    report_mismatch($sformatf("sub_cmd_c %02h, expected %02h",
                                              out_data.sub_cmd_c, want.sub_cmd_c));
                if (out_data.tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte %02h, expected %02h",
                                              out_data.tx_byte, want.tx_byte));
                if (out_data.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              out_data.last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        rst_n = 1'b0;
        p_timeout = TIMEOUT_RESET;
        for (int k = 0; k < FRAME_BYTES; k++)
            p_store[k] = 8'h00;
        p_index = 0;
        p_open = 1'b0;
        p_xor = 8'h00;
        p_ticks = 16'd0;
        p_rx_seq = 8'h00;
        p_ack_seq = 8'h00;
        p_sub = 8'h00;
        for (int k = 0; k < NUM_SLOTS; k++)
            p_slots[k] = 64'd0;
        in_idle_pct = 13;
        out_idle_pct = 47;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_item(directed[i].stim, directed[i].mode, directed[i].want);

        // zero timeout drops every header, timeout of one drops on the first tick
        set_timeout(16'd0);
        run_random(10);
        set_timeout(16'd1);
        run_random(40);

        in_idle_pct = 47;
        out_idle_pct = 13;
        set_timeout(16'hFFFF);
        run_random(48);
        set_timeout(16'($urandom_range(2, 40)));
        run_random(48);

        in_idle_pct = 0;
        out_idle_pct = 0;
        set_timeout(TIMEOUT_RESET);
        run_random(48);

        in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (due_outputs.size() != 0)
            report_mismatch($sformatf("%0d transactions never arrived", due_outputs.size()));
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
